>>> rtl/script_line_lexer_core_macros.svh
// ----------------------------------------------------------------------------
// script_line_lexer_core_macros.svh
// Assertion macros used by the lexer checker sll_checker.
// ----------------------------------------------------------------------------
`ifndef SCRIPT_LINE_LEXER_CORE_MACROS_SVH
`define SCRIPT_LINE_LEXER_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define SLL_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lexer check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define SLL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lexer check failed");

`endif

>>> rtl/sll_pkg.sv
// ----------------------------------------------------------------------------
// sll_pkg
// Token kinds, error codes and the event type of the script line lexer.
// ----------------------------------------------------------------------------
package sll_pkg;

   localparam logic [3:0] KIND_STRING = 4'd0;
   localparam logic [3:0] KIND_NUMBER = 4'd1;
   localparam logic [3:0] KIND_IDENT  = 4'd2;
   localparam logic [3:0] KIND_OPER   = 4'd3;
   localparam logic [3:0] KIND_COLON  = 4'd4;
   localparam logic [3:0] KIND_COMMA  = 4'd5;
   localparam logic [3:0] KIND_LPAREN = 4'd6;
   localparam logic [3:0] KIND_RPAREN = 4'd7;
   localparam logic [3:0] KIND_LBRACK = 4'd8;
   localparam logic [3:0] KIND_RBRACK = 4'd9;
   localparam logic [3:0] KIND_LBRACE = 4'd10;
   localparam logic [3:0] KIND_RBRACE = 4'd11;

   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
   localparam logic [1:0] ERR_NO_QUOTE   = 2'd2;
   localparam logic [1:0] ERR_BAD_EXP    = 2'd3;

   localparam int RSP_DATA_W = 16;
   localparam int REQ_DATA_W = 8;

   typedef struct packed {
      logic [3:0] kind;
      logic [7:0] value_byte;
      logic       has_byte;
      logic       token_first;
      logic       token_last;
      logic [1:0] error_code;
      logic       line_done;
      logic       last_beat;
   } lex_event_type;

endpackage

>>> rtl/script_line_lexer_core.sv
// ----------------------------------------------------------------------------
// script_line_lexer_core
// Token events are queued as their byte beat is taken and leave rsp in order.
// Throughput: one byte beat per cycle while two of four queue entries are free;
// a beat that closes one token and opens the next makes two rsp beats, rsp moves
// one event per cycle, so a run of such beats or an rsp stall holds req back.
// Reset: synchronous, active high; clears lexer mode, quote kind and queue.
// ----------------------------------------------------------------------------
module script_line_lexer_core (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: [7:0] char_in
   input  logic [sll_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                               req_tlast,   // line_end
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // rsp_tdata: [7:0] value_byte, [8] has_byte, [9] token_first,
   //            [10] token_last, [12:11] error_code, [13] line_done, [15:14] 0
   output logic [sll_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // rsp_tuser: [3:0] kind
   output logic [3:0]                         rsp_tuser,
   output logic                               rsp_tlast,   // last event of a beat
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready
);
   import sll_pkg::*;

   // Lexer mode codes.
   localparam logic [3:0] M_IDLE    = 4'd0;
   localparam logic [3:0] M_STR     = 4'd1;
   localparam logic [3:0] M_ESC     = 4'd2;
   localparam logic [3:0] M_INT     = 4'd3;
   localparam logic [3:0] M_FRAC    = 4'd4;
   localparam logic [3:0] M_EXPS    = 4'd5;
   localparam logic [3:0] M_EXPD    = 4'd6;
   localparam logic [3:0] M_IDENT   = 4'd7;
   localparam logic [3:0] M_OPER    = 4'd8;
   localparam logic [3:0] M_COMMENT = 4'd9;
   localparam logic [3:0] M_ERR     = 4'd10;

   // Character constants.
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DQ    = 8'h22;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_SQ    = 8'h27;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_RPAR  = 8'h29;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UE    = 8'h45;
   localparam logic [7:0] CH_UZ    = 8'h5A;
   localparam logic [7:0] CH_LBRK  = 8'h5B;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_RBRK  = 8'h5D;
   localparam logic [7:0] CH_USCR  = 8'h5F;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LE    = 8'h65;
   localparam logic [7:0] CH_LN    = 8'h6E;
   localparam logic [7:0] CH_LR    = 8'h72;
   localparam logic [7:0] CH_LT_T  = 8'h74;
   localparam logic [7:0] CH_LZ    = 8'h7A;
   localparam logic [7:0] CH_LBRC  = 8'h7B;
   localparam logic [7:0] CH_RBRC  = 8'h7D;

   // What a byte does when it lands between tokens.
   typedef struct packed {
      logic          hit;
      lex_event_type ev;
      logic [3:0]    mode;
      logic          quote;
   } start_type;

   function automatic lex_event_type mk_event(input logic [3:0] kind,
                                              input logic [7:0] val,
                                              input logic       hasb,
                                              input logic       first,
                                              input logic       closes,
                                              input logic [1:0] err,
                                              input logic       ldone);
      lex_event_type e;
      e.kind        = kind;
      e.value_byte  = val;
      e.has_byte    = hasb;
      e.token_first = first;
      e.token_last  = closes;
      e.error_code  = err;
      e.line_done   = ldone;
      e.last_beat   = 1'b0;
      return e;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_0) && (c <= CH_9);
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ)) ||
             is_digit(c) || (c == CH_USCR);
   endfunction

   function automatic logic is_op(input logic [7:0] c);
      return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH) ||
             (c == CH_EQ) || (c == CH_LT) || (c == CH_GT);
   endfunction

   function automatic start_type lex_start(input logic [7:0] c, input logic quote);
      start_type  s;
      logic [3:0] dk;
      dk      = KIND_STRING;
      s.hit   = 1'b1;
      s.ev    = mk_event(KIND_STRING, 8'd0, 1'b0, 1'b0, 1'b0, ERR_NONE, 1'b0);
      s.mode  = M_IDLE;
      s.quote = quote;
      case (c)
         CH_COLON: dk = KIND_COLON;
         CH_COMMA: dk = KIND_COMMA;
         CH_LPAR:  dk = KIND_LPAREN;
         CH_RPAR:  dk = KIND_RPAREN;
         CH_LBRK:  dk = KIND_LBRACK;
         CH_RBRK:  dk = KIND_RBRACK;
         CH_LBRC:  dk = KIND_LBRACE;
         CH_RBRC:  dk = KIND_RBRACE;
         default:  dk = KIND_STRING;
      endcase
      if ((c == CH_SPACE) || (c == CH_TAB)) begin
         s.hit = 1'b0;
      end else if (c == CH_HASH) begin
         s.hit  = 1'b0;
         s.mode = M_COMMENT;
      end else if ((c == CH_DQ) || (c == CH_SQ)) begin
         s.quote = (c == CH_DQ);
         s.ev    = mk_event(KIND_STRING, 8'd0, 1'b0, 1'b1, 1'b0, ERR_NONE, 1'b0);
         s.mode  = M_STR;
      end else if (is_digit(c)) begin
         s.ev   = mk_event(KIND_NUMBER, c, 1'b1, 1'b1, 1'b0, ERR_NONE, 1'b0);
         s.mode = M_INT;
      end else if (c == CH_DOT) begin
         s.ev   = mk_event(KIND_NUMBER, c, 1'b1, 1'b1, 1'b0, ERR_NONE, 1'b0);
         s.mode = M_FRAC;
      end else if (is_word(c)) begin
         s.ev   = mk_event(KIND_IDENT, c, 1'b1, 1'b1, 1'b0, ERR_NONE, 1'b0);
         s.mode = M_IDENT;
      end else if (is_op(c)) begin
         s.ev   = mk_event(KIND_OPER, c, 1'b1, 1'b1, 1'b0, ERR_NONE, 1'b0);
         s.mode = M_OPER;
      end else if (dk != KIND_STRING) begin
         s.ev = mk_event(dk, 8'd0, 1'b0, 1'b1, 1'b1, ERR_NONE, 1'b0);
      end else begin
         s.ev   = mk_event(KIND_STRING, c, 1'b1, 1'b0, 1'b0, ERR_UNEXPECTED, 1'b0);
         s.mode = M_ERR;
      end
      return s;
   endfunction

   // ---------------------------------------------------------------------
   // State
   // ---------------------------------------------------------------------
   logic [3:0]    mode_ff, mode_in;
   logic          quote_ff, quote_in;

   // Four-entry event queue; a byte beat is taken only with two slots free.
   lex_event_type queue_ff [4];
   logic [1:0]    wr_ptr_ff, wr_ptr_in;
   logic [1:0]    rd_ptr_ff, rd_ptr_in;
   logic [2:0]    count_ff, count_in;

   logic          req_take;
   logic          rsp_take;
   logic [7:0]    ch;
   logic [7:0]    quote_ch;
   start_type     st;
   lex_event_type ev0, ev1;
   logic          ev0_vld, ev1_vld;
   lex_event_type head;

   assign req_tready = !reset && (count_ff <= 3'd2);
   assign req_take   = req_tvalid && req_tready;
   assign rsp_tvalid = (count_ff != 3'd0);
   assign rsp_take   = rsp_tvalid && rsp_tready;
   assign ch         = req_tdata[7:0];
   assign quote_ch   = quote_ff ? CH_DQ : CH_SQ;

   // ---------------------------------------------------------------------
   // Per-beat lexing: at most a byte, close or line-end event, then a start event.
   // ---------------------------------------------------------------------
   always_comb begin
      st      = lex_start(ch, quote_ff);
      ev0     = mk_event(KIND_STRING, 8'd0, 1'b0, 1'b0, 1'b0, ERR_NONE, 1'b0);
      ev1     = ev0;
      ev0_vld = 1'b0;
      ev1_vld = 1'b0;
      mode_in = mode_ff;
      quote_in = quote_ff;
      if (req_tlast) begin
         ev0_vld  = 1'b1;
         mode_in  = M_IDLE;
         quote_in = 1'b0;
         case (mode_ff)
            M_INT, M_FRAC, M_EXPD: begin
               ev0 = mk_event(KIND_NUMBER, 8'd0, 1'b0, 1'b0, 1'b1, ERR_NONE, 1'b1);
            end
            M_IDENT: begin
               ev0 = mk_event(KIND_IDENT, 8'd0, 1'b0, 1'b0, 1'b1, ERR_NONE, 1'b1);
            end
            M_OPER: begin
               ev0 = mk_event(KIND_OPER, 8'd0, 1'b0, 1'b0, 1'b1, ERR_NONE, 1'b1);
            end
            M_STR, M_ESC: begin
               ev0 = mk_event(KIND_STRING, 8'd0, 1'b0, 1'b0, 1'b0, ERR_NO_QUOTE, 1'b1);
            end
            M_EXPS: begin
               ev0 = mk_event(KIND_NUMBER, 8'd0, 1'b0, 1'b0, 1'b0, ERR_BAD_EXP, 1'b1);
            end
            default: begin
               ev0 = mk_event(KIND_STRING, 8'd0, 1'b0, 1'b0, 1'b0, ERR_NONE, 1'b1);
            end
         endcase
      end else begin
         case (mode_ff)
            M_STR: begin
               ev0_vld = 1'b1;
               if (ch == quote_ch) begin
                  ev0     = mk_event(KIND_STRING, 8'd0, 1'b0, 1'b0, 1'b1, ERR_NONE, 1'b0);
                  mode_in = M_IDLE;
               end else if (ch == CH_BSL) begin
                  ev0_vld = 1'b0;
                  mode_in = M_ESC;
               end else begin
                  ev0 = mk_event(KIND_STRING, ch, 1'b1, 1'b0, 1'b0, ERR_NONE, 1'b0);
               end
            end
            M_ESC: begin
               // unknown escapes are dropped
               mode_in = M_STR;
               ev0_vld = 1'b1;
               if (ch == CH_LT_T) begin
                  ev0 = mk_event(KIND_STRING, CH_TAB, 1'b1, 1'b0, 1'b0, ERR_NONE, 1'b0);
               end else if (ch == CH_LN) begin
                  ev0 = mk_event(KIND_STRING, CH_LF, 1'b1, 1'b0, 1'b0, ERR_NONE, 1'b0);
               end else if (ch == CH_LR) begin
                  ev0 = mk_event(KIND_STRING, CH_CR, 1'b1, 1'b0, 1'b0, ERR_NONE, 1'b0);
               end else if ((ch == CH_DQ) || (ch == CH_SQ) || (ch == CH_BSL)) begin
                  ev0 = mk_event(KIND_STRING, ch, 1'b1, 1'b0, 1'b0, ERR_NONE, 1'b0);
               end else begin
                  ev0_vld = 1'b0;
               end
            end
            M_INT, M_FRAC, M_EXPD: begin
               ev0_vld = 1'b1;
               if (is_digit(ch)) begin
                  ev0 = mk_event(KIND_NUMBER, ch, 1'b1, 1'b0, 1'b0, ERR_NONE, 1'b0);
               end else if ((mode_ff == M_INT) && (ch == CH_DOT)) begin
                  ev0     = mk_event(KIND_NUMBER, ch, 1'b1, 1'b0, 1'b0, ERR_NONE, 1'b0);
                  mode_in = M_FRAC;
               end else if ((mode_ff != M_EXPD) && ((ch == CH_LE) || (ch == CH_UE))) begin
                  ev0     = mk_event(KIND_NUMBER, ch, 1'b1, 1'b0, 1'b0, ERR_NONE, 1'b0);
                  mode_in = M_EXPS;
               end else begin
                  // number closed; byte relexed between tokens
                  ev0      = mk_event(KIND_NUMBER, 8'd0, 1'b0, 1'b0, 1'b1, ERR_NONE, 1'b0);
                  ev1      = st.ev;
                  ev1_vld  = st.hit;
                  mode_in  = st.mode;
                  quote_in = st.quote;
               end
            end
            M_EXPS: begin
               ev0_vld = 1'b1;
               if ((ch == CH_PLUS) || (ch == CH_MINUS) || is_digit(ch)) begin
                  ev0     = mk_event(KIND_NUMBER, ch, 1'b1, 1'b0, 1'b0, ERR_NONE, 1'b0);
                  mode_in = M_EXPD;
               end else begin
                  ev0     = mk_event(KIND_NUMBER, ch, 1'b1, 1'b0, 1'b0, ERR_BAD_EXP, 1'b0);
                  mode_in = M_ERR;
               end
            end
            M_IDENT: begin
               ev0_vld = 1'b1;
               if (is_word(ch)) begin
                  ev0 = mk_event(KIND_IDENT, ch, 1'b1, 1'b0, 1'b0, ERR_NONE, 1'b0);
               end else begin
                  ev0      = mk_event(KIND_IDENT, 8'd0, 1'b0, 1'b0, 1'b1, ERR_NONE, 1'b0);
                  ev1      = st.ev;
                  ev1_vld  = st.hit;
                  mode_in  = st.mode;
                  quote_in = st.quote;
               end
            end
            M_OPER: begin
               ev0_vld = 1'b1;
               if (is_op(ch)) begin
                  ev0 = mk_event(KIND_OPER, ch, 1'b1, 1'b0, 1'b0, ERR_NONE, 1'b0);
               end else begin
                  ev0      = mk_event(KIND_OPER, 8'd0, 1'b0, 1'b0, 1'b1, ERR_NONE, 1'b0);
                  ev1      = st.ev;
                  ev1_vld  = st.hit;
                  mode_in  = st.mode;
                  quote_in = st.quote;
               end
            end
            M_COMMENT, M_ERR: begin
               // rest of line is skipped
               mode_in = mode_ff;
            end
            default: begin
               // idle, and any unused mode code
               ev0      = st.ev;
               ev0_vld  = st.hit;
               mode_in  = st.mode;
               quote_in = st.quote;
            end
         endcase
      end
      ev0.last_beat = !ev1_vld;
      ev1.last_beat = 1'b1;
   end

   // ---------------------------------------------------------------------
   // Queue pointers and count
   // ---------------------------------------------------------------------
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (req_take) begin
         wr_ptr_in = wr_ptr_ff + {1'b0, ev0_vld} + {1'b0, ev1_vld};
         count_in  = count_ff + {2'b00, ev0_vld} + {2'b00, ev1_vld};
      end
      rd_ptr_in = rsp_take ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      if (rsp_take) begin
         count_in = count_in - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= M_IDLE;
         quote_ff  <= 1'b0;
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         if (req_take) begin
            mode_ff  <= mode_in;
            quote_ff <= quote_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue payload, no reset needed.
   always_ff @(posedge clock) begin
      if (req_take && ev0_vld) begin
         queue_ff[wr_ptr_ff] <= ev0;
      end
      if (req_take && ev1_vld) begin
         queue_ff[wr_ptr_ff + 2'd1] <= ev1;
      end
   end

   // ---------------------------------------------------------------------
   // Result beat
   // ---------------------------------------------------------------------
   assign head      = queue_ff[rd_ptr_ff];
   assign rsp_tdata = {2'b00, head.line_done, head.error_code, head.token_last,
                       head.token_first, head.has_byte, head.value_byte};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last_beat;

endmodule

>>> rtl/sll_checker.sv
// ----------------------------------------------------------------------------
// sll_checker
// Port-level checks for script_line_lexer_core, attached by bind.
// ----------------------------------------------------------------------------
`include "script_line_lexer_core_macros.svh"

module sll_checker (
   input logic                           clock,
   input logic                           reset,
   input logic [sll_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic                           req_tlast,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [sll_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [3:0]                     rsp_tuser,
   input logic                           rsp_tlast,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready
);
   import sll_pkg::*;

   logic stalled;
   logic line_beat;
   logic err_beat;

   assign stalled   = rsp_tvalid && !rsp_tready;
   assign line_beat = req_tvalid && req_tready && req_tlast && (req_tdata == req_tdata);
   assign err_beat  = rsp_tvalid && (rsp_tdata[12:11] != ERR_NONE);

   // reset empties the event queue
   `SLL_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)
   // a line end always yields at least one event
   `SLL_ASSERT_NEXT(a_line_end_event, clock, reset, line_beat, rsp_tvalid)
   // an error event carries the offending byte unless raised by a line end
   `SLL_ASSERT_IMPL(a_err_byte, clock, reset, err_beat, rsp_tdata[8] || rsp_tdata[13])
   // held result beat does not change
   `SLL_ASSERT_NEXT(a_rsp_hold, clock, reset, stalled,
                    rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

endmodule

bind script_line_lexer_core sll_checker u_sll_checker (.*);

>>> tb/script_line_lexer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// script_line_lexer_checker
// Watches the req and rsp streams of the lexer. It keeps its own lexer mode
// and quote kind, works out the token events of each req beat and compares
// every rsp beat, field by field, with the oldest event still owed.
// ----------------------------------------------------------------------------
module script_line_lexer_checker (
   input  logic                           clock,
   input  logic                           reset,
   // req_tdata: [7:0] char_in
   input  logic [sll_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tlast,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   // rsp_tdata: [7:0] value_byte, [8] has_byte, [9] token_first,
   //            [10] token_last, [12:11] error_code, [13] line_done, [15:14] 0
   input  logic [sll_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // rsp_tuser: [3:0] kind
   input  logic [3:0]                     rsp_tuser,
   input  logic                           rsp_tlast,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output int                             fail_count,
   output int                             pending_count,
   output int                             lexed_items,
   output int                             events_checked
);
   import sll_pkg::*;

   localparam int MAX_REPORTS = 10;

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = " ";
   localparam logic [7:0] CH_HASH   = "#";
   localparam logic [7:0] CH_DQUOTE = "\"";
   localparam logic [7:0] CH_SQUOTE = "'";
   localparam logic [7:0] CH_BSLASH = "\\";
   localparam logic [7:0] CH_DOT    = ".";
   localparam logic [7:0] CH_UNDER  = "_";
   localparam logic [7:0] CH_LOW_E  = "e";
   localparam logic [7:0] CH_UP_E   = "E";
   localparam logic [7:0] CH_PLUS   = "+";
   localparam logic [7:0] CH_MINUS  = "-";
   localparam logic [7:0] CH_LOW_T  = "t";
   localparam logic [7:0] CH_LOW_N  = "n";
   localparam logic [7:0] CH_LOW_R  = "r";
   localparam logic [7:0] CH_COLON  = ":";
   localparam logic [7:0] CH_COMMA  = ",";
   localparam logic [7:0] CH_LPAREN = "(";
   localparam logic [7:0] CH_RPAREN = ")";
   localparam logic [7:0] CH_LBRACK = "[";
   localparam logic [7:0] CH_RBRACK = "]";
   localparam logic [7:0] CH_LBRACE = "{";
   localparam logic [7:0] CH_RBRACE = "}";

   typedef enum logic [3:0] {
      LX_IDLE, LX_STRING, LX_ESCAPE, LX_INT, LX_FRAC, LX_EXP_SIGN, LX_EXP_DIGITS,
      LX_IDENT, LX_OPER, LX_COMMENT, LX_ERROR
   } lex_mode_type;

   lex_mode_type  mode = LX_IDLE;
   logic          quote_dbl = 1'b0;
   lex_event_type beat_events[$];   // events of the beat being lexed
   lex_event_type owed_events[$];   // events still owed by the block, oldest first
   int            mismatches = 0;
   int            checked = 0;
   int            lexed = 0;

   function automatic bit is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_word(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || is_digit(c) ||
             c == CH_UNDER;
   endfunction

   function automatic bit is_op(input logic [7:0] c);
      return c == CH_PLUS || c == CH_MINUS || c == "*" || c == "/" || c == "=" ||
             c == "<" || c == ">";
   endfunction

   // KIND_STRING here means "not a delimiter"
   function automatic logic [3:0] delim_kind(input logic [7:0] c);
      case (c)
         CH_COLON:  return KIND_COLON;
         CH_COMMA:  return KIND_COMMA;
         CH_LPAREN: return KIND_LPAREN;
         CH_RPAREN: return KIND_RPAREN;
         CH_LBRACK: return KIND_LBRACK;
         CH_RBRACK: return KIND_RBRACK;
         CH_LBRACE: return KIND_LBRACE;
         CH_RBRACE: return KIND_RBRACE;
         default:   return KIND_STRING;
      endcase
   endfunction

   function automatic string event_text(input lex_event_type e);
      return $sformatf("kind=%0d byte=%h has=%b first=%b close=%b err=%0d done=%b tlast=%b",
                       e.kind, e.value_byte, e.has_byte, e.token_first, e.token_last,
                       e.error_code, e.line_done, e.last_beat);
   endfunction

   task automatic add_event(input logic [3:0] kind, input logic [7:0] val, input logic hasb,
                            input logic first, input logic closes, input logic [1:0] err,
                            input logic ldone);
      lex_event_type ev;
      ev.kind        = kind;
      ev.value_byte  = val;
      ev.has_byte    = hasb;
      ev.token_first = first;
      ev.token_last  = closes;
      ev.error_code  = err;
      ev.line_done   = ldone;
      ev.last_beat   = 1'b0;
      beat_events    = {beat_events, ev};
   endtask

   // a byte seen between tokens
   task automatic lex_between(input logic [7:0] c);
      logic [3:0] dk;
      dk   = delim_kind(c);
      mode = LX_IDLE;
      if (c == CH_SPACE || c == CH_TAB) begin
      end else if (c == CH_HASH) begin
         mode = LX_COMMENT;
      end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
         quote_dbl = (c == CH_DQUOTE);
         add_event(KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b0, ERR_NONE, 1'b0);
         mode = LX_STRING;
      end else if (is_digit(c)) begin
         add_event(KIND_NUMBER, c, 1'b1, 1'b1, 1'b0, ERR_NONE, 1'b0);
         mode = LX_INT;
      end else if (c == CH_DOT) begin
         add_event(KIND_NUMBER, c, 1'b1, 1'b1, 1'b0, ERR_NONE, 1'b0);
         mode = LX_FRAC;
      end else if (is_word(c)) begin
         add_event(KIND_IDENT, c, 1'b1, 1'b1, 1'b0, ERR_NONE, 1'b0);
         mode = LX_IDENT;
      end else if (is_op(c)) begin
         add_event(KIND_OPER, c, 1'b1, 1'b1, 1'b0, ERR_NONE, 1'b0);
         mode = LX_OPER;
      end else if (dk != KIND_STRING) begin
         add_event(dk, 8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE, 1'b0);
      end else begin
         add_event(KIND_STRING, c, 1'b1, 1'b0, 1'b0, ERR_UNEXPECTED, 1'b0);
         mode = LX_ERROR;
      end
   endtask

   task automatic close_and_restart(input logic [3:0] kind, input logic [7:0] c);
      add_event(kind, 8'h00, 1'b0, 1'b0, 1'b1, ERR_NONE, 1'b0);
      lex_between(c);
   endtask

   task automatic lex_line_end();
      case (mode)
         LX_INT, LX_FRAC, LX_EXP_DIGITS:
            add_event(KIND_NUMBER, 8'h00, 1'b0, 1'b0, 1'b1, ERR_NONE, 1'b1);
         LX_IDENT:
            add_event(KIND_IDENT, 8'h00, 1'b0, 1'b0, 1'b1, ERR_NONE, 1'b1);
         LX_OPER:
            add_event(KIND_OPER, 8'h00, 1'b0, 1'b0, 1'b1, ERR_NONE, 1'b1);
         LX_STRING, LX_ESCAPE:
            add_event(KIND_STRING, 8'h00, 1'b0, 1'b0, 1'b0, ERR_NO_QUOTE, 1'b1);
         LX_EXP_SIGN:
            add_event(KIND_NUMBER, 8'h00, 1'b0, 1'b0, 1'b0, ERR_BAD_EXP, 1'b1);
         default:
            add_event(KIND_STRING, 8'h00, 1'b0, 1'b0, 1'b0, ERR_NONE, 1'b1);
      endcase
      mode      = LX_IDLE;
      quote_dbl = 1'b0;
   endtask

   task automatic lex_char(input logic [7:0] c);
      logic [7:0] closing;
      closing = quote_dbl ? CH_DQUOTE : CH_SQUOTE;
      case (mode)
         LX_STRING: begin
            if (c == closing) begin
               add_event(KIND_STRING, 8'h00, 1'b0, 1'b0, 1'b1, ERR_NONE, 1'b0);
               mode = LX_IDLE;
            end else if (c == CH_BSLASH) begin
               mode = LX_ESCAPE;
            end else begin
               add_event(KIND_STRING, c, 1'b1, 1'b0, 1'b0, ERR_NONE, 1'b0);
            end
         end
         LX_ESCAPE: begin
            // unknown escapes vanish
            if (c == CH_LOW_T)
               add_event(KIND_STRING, CH_TAB, 1'b1, 1'b0, 1'b0, ERR_NONE, 1'b0);
            else if (c == CH_LOW_N)
               add_event(KIND_STRING, CH_LF, 1'b1, 1'b0, 1'b0, ERR_NONE, 1'b0);
            else if (c == CH_LOW_R)
               add_event(KIND_STRING, CH_CR, 1'b1, 1'b0, 1'b0, ERR_NONE, 1'b0);
            else if (c == CH_DQUOTE || c == CH_SQUOTE || c == CH_BSLASH)
               add_event(KIND_STRING, c, 1'b1, 1'b0, 1'b0, ERR_NONE, 1'b0);
            mode = LX_STRING;
         end
         LX_INT: begin
            if (is_digit(c)) begin
               add_event(KIND_NUMBER, c, 1'b1, 1'b0, 1'b0, ERR_NONE, 1'b0);
            end else if (c == CH_DOT) begin
               add_event(KIND_NUMBER, c, 1'b1, 1'b0, 1'b0, ERR_NONE, 1'b0);
               mode = LX_FRAC;
            end else if (c == CH_LOW_E || c == CH_UP_E) begin
               add_event(KIND_NUMBER, c, 1'b1, 1'b0, 1'b0, ERR_NONE, 1'b0);
               mode = LX_EXP_SIGN;
            end else begin
               close_and_restart(KIND_NUMBER, c);
            end
         end
         LX_FRAC: begin
            if (is_digit(c)) begin
               add_event(KIND_NUMBER, c, 1'b1, 1'b0, 1'b0, ERR_NONE, 1'b0);
            end else if (c == CH_LOW_E || c == CH_UP_E) begin
               add_event(KIND_NUMBER, c, 1'b1, 1'b0, 1'b0, ERR_NONE, 1'b0);
               mode = LX_EXP_SIGN;
            end else begin
               close_and_restart(KIND_NUMBER, c);
            end
         end
         LX_EXP_SIGN: begin
            if (c == CH_PLUS || c == CH_MINUS || is_digit(c)) begin
               add_event(KIND_NUMBER, c, 1'b1, 1'b0, 1'b0, ERR_NONE, 1'b0);
               mode = LX_EXP_DIGITS;
            end else begin
               add_event(KIND_NUMBER, c, 1'b1, 1'b0, 1'b0, ERR_BAD_EXP, 1'b0);
               mode = LX_ERROR;
            end
         end
         LX_EXP_DIGITS: begin
            if (is_digit(c)) add_event(KIND_NUMBER, c, 1'b1, 1'b0, 1'b0, ERR_NONE, 1'b0);
            else close_and_restart(KIND_NUMBER, c);
         end
         LX_IDENT: begin
            if (is_word(c)) add_event(KIND_IDENT, c, 1'b1, 1'b0, 1'b0, ERR_NONE, 1'b0);
            else close_and_restart(KIND_IDENT, c);
         end
         LX_OPER: begin
            if (is_op(c)) add_event(KIND_OPER, c, 1'b1, 1'b0, 1'b0, ERR_NONE, 1'b0);
            else close_and_restart(KIND_OPER, c);
         end
         LX_COMMENT, LX_ERROR: ;
         default: lex_between(c);
      endcase
   endtask

   always @(posedge clock) begin : monitor
      lex_event_type got;
      lex_event_type want;
      if (reset) begin
         mode      = LX_IDLE;
         quote_dbl = 1'b0;
         owed_events.delete();
      end else begin
         // rsp first: an event never leaves in the cycle its byte is taken
         if (rsp_tvalid && rsp_tready) begin
            got.kind        = rsp_tuser;
            got.value_byte  = rsp_tdata[7:0];
            got.has_byte    = rsp_tdata[8];
            got.token_first = rsp_tdata[9];
            got.token_last  = rsp_tdata[10];
            got.error_code  = rsp_tdata[12:11];
            got.line_done   = rsp_tdata[13];
            got.last_beat   = rsp_tlast;
            checked++;
            if (owed_events.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: rsp beat with no event owed: %s", $realtime,
                           event_text(got));
            end else begin
               want = owed_events.pop_front();
               if (got !== want || rsp_tdata[15:14] !== 2'b00) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS) begin
                     $display("%0t: rsp mismatch on event %0d", $realtime, checked);
                     $display("   expected %s pad=00", event_text(want));
                     $display("   actual   %s pad=%b", event_text(got),
                              rsp_tdata[15:14]);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tlast || (mode != LX_COMMENT && mode != LX_ERROR)) lexed++;
            beat_events.delete();
            if (req_tlast) lex_line_end();
            else lex_char(req_tdata[7:0]);
            if (beat_events.size() > 0)
               beat_events[beat_events.size() - 1].last_beat = 1'b1;
            owed_events = {owed_events, beat_events};
         end
      end
      fail_count     <= mismatches;
      pending_count  <= owed_events.size();
      lexed_items    <= lexed;
      events_checked <= checked;
   end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives source lines into the script line lexer, one byte per req beat and
// a closing line-end beat, and lets the checker score every token event. A
// few hand-picked lines come first, then random lines built mostly from
// well-formed tokens with some noise bytes and broken tokens mixed in.
// ----------------------------------------------------------------------------
module tb;
   import sll_pkg::*;

   localparam int ITEM_TARGET  = 1600;     // req beats wanted in total
   localparam int CYCLE_LIMIT  = 200000;   // far above a slow but correct run
   localparam int IDLE_PCT     = 12;       // chance of a gap or stall per cycle
   localparam int DRAIN_CYCLES = 20;       // quiet time after the last event
   localparam int QUIET_FROM   = 600;      // req-beat window with no gaps/stalls
   localparam int QUIET_TO     = 900;

   localparam string IDENT_HEAD = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
   localparam string IDENT_TAIL = "abcxyzEeTtNnR_0123456789";
   localparam string TEXT_CHARS = "abzAZ09 #.:+e_\t";

   logic                  clock = 1'b0;
   logic                  reset;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tlast;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [3:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;

   int   fail_count;
   int   pending_count;
   int   lexed_items;
   int   events_checked;
   int   cycle_count = 0;
   int   lines_sent = 0;
   int   beats_sent = 0;
   bit   pace_on = 1'b1;      // gaps on req and stalls on rsp allowed
   logic [7:0] line_bytes[$]; // bytes of the line about to go out

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   script_line_lexer_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   script_line_lexer_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .fail_count     (fail_count),
      .pending_count  (pending_count),
      .lexed_items    (lexed_items),
      .events_checked (events_checked)
   );

   // Receiver side: random stalls, one update per falling edge.
   always @(negedge clock) begin
      rsp_tready <= !(pace_on && $urandom_range(0, 99) < IDLE_PCT);
   end

   // Watchdog: a hung handshake or a lost event ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped at the cycle limit, %0d events still owed", pending_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic logic [7:0] pick(input string s);
      return s[$urandom_range(0, s.len() - 1)];
   endfunction

   // One req beat. Random gaps come first, each a falling edge with tvalid low
   // and junk on tdata, then the beat is held until the block takes it.
   task automatic send_beat(input logic [7:0] ch, input logic line_end);
      while (pace_on && $urandom_range(0, 99) < IDLE_PCT) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom_range(0, 255));
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= line_end;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      beats_sent++;
   endtask

   // Sends line_bytes, then the line-end beat with a junk byte beside it.
   task automatic send_line();
      foreach (line_bytes[i]) send_beat(line_bytes[i], 1'b0);
      send_beat(8'($urandom_range(0, 255)), 1'b1);
      lines_sent++;
   endtask

   // Appends one byte to the line being built.
   task automatic put_byte(input logic [7:0] b);
      line_bytes = {line_bytes, b};
   endtask

   task automatic send_text(input string s);
      line_bytes.delete();
      for (int i = 0; i < s.len(); i++) put_byte(s[i]);
      send_line();
   endtask

   task automatic add_digits(input int count);
      for (int i = 0; i < count; i++) put_byte(pick("0123456789"));
   endtask

   // Random line: mostly well-formed tokens with optional blanks between
   // them (no blank lets neighbors run together), plus some comments,
   // unterminated strings, bad exponents and raw noise bytes.
   task automatic build_random_line();
      int         n_tok;
      int         roll;
      int         len;
      logic [7:0] quote;
      logic [7:0] b;
      line_bytes.delete();
      n_tok = $urandom_range(1, 6);
      for (int k = 0; k < n_tok; k++) begin
         if (k > 0 && $urandom_range(0, 3) != 0) begin
            put_byte(pick(" \t"));
            if ($urandom_range(0, 3) == 0) put_byte(pick(" \t"));
         end
         roll = $urandom_range(0, 99);
         if (roll < 22) begin
            // number: lone dot start, int part, fraction, exponent
            if ($urandom_range(0, 4) == 0) begin
               put_byte(".");
               add_digits($urandom_range(0, 2));
            end else begin
               add_digits($urandom_range(1, 4));
               if ($urandom_range(0, 1) == 1) begin
                  put_byte(".");
                  add_digits($urandom_range(0, 3));
               end
            end
            if ($urandom_range(0, 9) < 3) begin
               put_byte(pick("eE"));
               if ($urandom_range(0, 1) == 1) begin
                  put_byte(pick("+-"));
                  add_digits($urandom_range(0, 2));
               end else begin
                  add_digits($urandom_range(1, 2));
               end
            end
         end else if (roll < 42) begin
            put_byte(pick(IDENT_HEAD));
            len = $urandom_range(0, 5);
            repeat (len) put_byte(pick(IDENT_TAIL));
         end else if (roll < 54) begin
            len = $urandom_range(1, 3);
            repeat (len) put_byte(pick("+-*/=<>"));
         end else if (roll < 66) begin
            put_byte(pick(":,()[]{}"));
         end else if (roll < 84) begin
            // string: plain text, the other quote, escapes known and unknown,
            // raw bytes; one in ten is left open
            quote = pick("\"'");
            put_byte(quote);
            len = $urandom_range(0, 6);
            repeat (len) begin
               roll = $urandom_range(0, 99);
               if (roll < 50) begin
                  put_byte(pick(TEXT_CHARS));
               end else if (roll < 60) begin
                  put_byte(quote == "'" ? "\"" : "'");
               end else if (roll < 80) begin
                  put_byte("\\");
                  put_byte(pick("tnr\"'\\qx0"));
               end else begin
                  do b = 8'($urandom_range(0, 255)); while (b == quote || b == "\\");
                  put_byte(b);
               end
            end
            if ($urandom_range(0, 9) != 0) put_byte(quote);
         end else if (roll < 90) begin
            // comment swallows the rest of the line
            put_byte("#");
            len = $urandom_range(0, 4);
            repeat (len) put_byte(8'($urandom_range(0, 255)));
            k = n_tok;
         end else if (roll < 93) begin
            // exponent marker followed by something that is not a sign or digit
            add_digits($urandom_range(1, 2));
            put_byte(pick("eE"));
            put_byte(pick("xe.#_ ("));
         end else begin
            put_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      rsp_tready = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed lines.
      // Double-quoted string: escaped tab, the other quote as text, then the
      // line ends right after a backslash -> missing closing quote.
      send_text("\"\\t'\\");
      // Identifier closed by a dot, the dot opens a number with a bare
      // fraction, line ends while the exponent still wants its sign.
      send_text("x.5e");
      // Operator closed by a brace (two events on one beat), then a number
      // whose exponent meets a bad byte; the rest of the line is skipped.
      send_text("+{1E?(");
      // NUL cannot start a token; the 0xFF after it is skipped.
      line_bytes = '{8'h00, 8'hFF};
      send_line();
      // Second dot ends the number and opens a new one; '#' closes that one
      // and starts a comment.
      send_text("7..#");

      // Random lines until enough beats have gone out, with a window where
      // neither side idles.
      while (beats_sent < ITEM_TARGET) begin
         pace_on = !(beats_sent >= QUIET_FROM && beats_sent < QUIET_TO);
         build_random_line();
         send_line();
      end
      pace_on = 1'b1;
      @(negedge clock);
      req_tvalid <= 1'b0;

      // Drain: every owed event has to show up, then nothing more may.
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d lines as %0d req beats, %0d of them lexed outside comments",
               lines_sent, beats_sent, lexed_items);
      $display("Scored %0d token events, %0d failed", events_checked, fail_count);
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
